// ----- hdl/rsc_pkg.sv -----
// shared types, constants and command/status structs of the rpn stack calculator
package rsc_pkg;

	localparam int DATA_W          = 32;
	localparam int ACT_W           = 3;
	localparam int ST_W            = 3;
	localparam int DEPTH_W         = 5;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int STEP_W          = $clog2(DATA_W);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH = 3'd0,
		ACT_DROP = 3'd1,
		ACT_MIN  = 3'd2,
		ACT_ADD  = 3'd3,
		ACT_SUB  = 3'd4,
		ACT_DIV  = 3'd5,
		ACT_MUL  = 3'd6
	} act_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 3'd0,
		ST_FEW   = 3'd1,
		ST_FULL  = 3'd2,
		ST_DIV0  = 3'd3,
		ST_EMPTY = 3'd4
	} st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DROP_LD,
		S_OP_A,
		S_DIV_RUN,
		S_OP_WR,
		S_MIN_RD,
		S_MIN_CMP,
		S_MIN_WR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RA_IDX,
		RA_IDX_P1,
		RA_CNT_M2
	} raddr_sel_t;

	typedef enum logic {
		WA_CNT,
		WA_CNT_M2
	} waddr_sel_t;

	typedef enum logic [1:0] {
		TOP_OPND,
		TOP_RES,
		TOP_RDATA
	} top_sel_t;

	typedef enum logic [1:0] {
		RES_ALU,
		RES_DIV,
		RES_MIN
	} res_sel_t;

	typedef struct packed {
		logic       latch_in;
		logic       st_ld;
		st_t        st;
		raddr_sel_t ra;
		logic       we;
		waddr_sel_t wa;
		logic       wd_opnd;
		logic       top_ld;
		top_sel_t   top_sel;
		logic       res_ld;
		res_sel_t   res_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       idx_clr;
		logic       idx_inc;
		logic       div_start;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic cnt_zero;
		logic cnt_lt2;
		logic cnt_full;
		logic b_zero;
		logic idx_last;
		logic div_done;
	} sts_t;

endpackage

// ----- hdl/rsc_ram.sv -----
// generic single-write, single-read ram with registered read data
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/rsc_div.sv -----
// iterative signed divider, truncating toward zero, one quotient bit per cycle
module rsc_div import rsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] mb_q;
	logic              neg_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] ma;
	logic [DATA_W-1:0] mb;

	assign ma     = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mb     = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ma;
			mb_q  <= mb;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// ----- hdl/rsc_dp.sv -----
// datapath: stack ram, entry count, top cache, alu, divider, min walk and result registers
module rsc_dp import rsc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] operand,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       stack_depth
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	act_t                act_q;
	logic [DATA_W-1:0]   opnd_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       idx_q;
	logic [DATA_W-1:0]   top_q;
	logic [DATA_W-1:0]   res_q;
	st_t                 st_q;
	logic [ST_W-1:0]     out_st_q;
	logic [DATA_W-1:0]   out_top_q;
	logic [DEPTH_W-1:0]  out_depth_q;

	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_m2;
	logic [AW-1:0]       idx_p1;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [DATA_W-1:0]   wdata;
	logic [DATA_W-1:0]   rdata;
	logic [DATA_W-1:0]   alu;
	logic [DATA_W-1:0]   div_q;
	logic                div_done;
	logic [CW+DEPTH_W-1:0] cnt_ext;

	assign cnt_m1  = cnt_q - CW'(1);
	assign cnt_m2  = cnt_q - CW'(2);
	assign idx_p1  = idx_q + AW'(1);
	assign cnt_ext = {{DEPTH_W{1'b0}}, cnt_q};

	always_comb begin
		case (cmd.ra)
			RA_IDX:    raddr = idx_q;
			RA_IDX_P1: raddr = idx_p1;
			RA_CNT_M2: raddr = cnt_m2[AW-1:0];
			default:   raddr = idx_q;
		endcase
	end

	assign waddr = (cmd.wa == WA_CNT) ? cnt_q[AW-1:0] : cnt_m2[AW-1:0];
	assign wdata = cmd.wd_opnd ? opnd_q : res_q;

	rsc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rdata),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		case (act_q)
			ACT_ADD: alu = rdata + top_q;
			ACT_SUB: alu = rdata - top_q;
			ACT_MUL: alu = rdata * top_q;
			default: alu = rdata + top_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q  <= act_t'(action);
			opnd_q <= operand;
		end
		if (cmd.st_ld) begin
			st_q <= cmd.st;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end
		if (cmd.top_ld) begin
			case (cmd.top_sel)
				TOP_OPND:  top_q <= opnd_q;
				TOP_RES:   top_q <= res_q;
				TOP_RDATA: top_q <= rdata;
				default:   top_q <= res_q;
			endcase
		end
		if (cmd.res_ld) begin
			case (cmd.res_sel)
				RES_ALU: res_q <= alu;
				RES_DIV: res_q <= div_q;
				RES_MIN: begin
					if (idx_q == '0 || $signed(rdata) < $signed(res_q)) begin
						res_q <= rdata;
					end
				end
				default: res_q <= alu;
			endcase
		end
		if (cmd.out_ld) begin
			out_st_q    <= st_q;
			out_top_q   <= (cnt_q == '0) ? '0 : top_q;
			out_depth_q <= cnt_ext[DEPTH_W-1:0];
		end
	end

	assign sts.action   = act_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_lt2  = (cnt_q < CW'(2));
	assign sts.cnt_full = (cnt_q >= CW'(STACK_DEPTH));
	assign sts.b_zero   = (top_q == '0);
	assign sts.idx_last = (CW'(idx_q) == cnt_m1);
	assign sts.div_done = div_done;

	assign status      = out_st_q;
	assign top_value   = out_top_q;
	assign stack_depth = out_depth_q;

endmodule

// ----- hdl/rsc_ctrl.sv -----
// controller state machine: sequences each action and drives the handshakes
module rsc_ctrl import rsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.st_ld = 1'b1;
				cmd.st    = ST_OK;
				state_d   = S_DONE;
				case (sts.action)
					ACT_PUSH: begin
						if (sts.cnt_full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.we      = 1'b1;
							cmd.wa      = WA_CNT;
							cmd.wd_opnd = 1'b1;
							cmd.top_ld  = 1'b1;
							cmd.top_sel = TOP_OPND;
							cmd.cnt_inc = 1'b1;
						end
					end
					ACT_DROP: begin
						if (sts.cnt_zero) begin
							cmd.st = ST_EMPTY;
						end else begin
							cmd.ra      = RA_CNT_M2;
							cmd.cnt_dec = 1'b1;
							state_d     = S_DROP_LD;
						end
					end
					ACT_MIN: begin
						if (sts.cnt_lt2) begin
							cmd.st = ST_FEW;
						end else if (sts.cnt_full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_MIN_RD;
						end
					end
					ACT_ADD, ACT_SUB, ACT_DIV, ACT_MUL: begin
						if (sts.cnt_lt2) begin
							cmd.st = ST_FEW;
						end else if (sts.action == ACT_DIV && sts.b_zero) begin
							cmd.st = ST_DIV0;
						end else begin
							cmd.ra  = RA_CNT_M2;
							state_d = S_OP_A;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_DROP_LD: begin
				cmd.top_ld  = 1'b1;
				cmd.top_sel = TOP_RDATA;
				state_d     = S_DONE;
			end
			S_OP_A: begin
				if (sts.action == ACT_DIV) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV_RUN;
				end else begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_ALU;
					state_d     = S_OP_WR;
				end
			end
			S_DIV_RUN: begin
				if (sts.div_done) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_DIV;
					state_d     = S_OP_WR;
				end
			end
			S_OP_WR: begin
				cmd.we      = 1'b1;
				cmd.wa      = WA_CNT_M2;
				cmd.top_ld  = 1'b1;
				cmd.top_sel = TOP_RES;
				cmd.cnt_dec = 1'b1;
				state_d     = S_DONE;
			end
			S_MIN_RD: begin
				cmd.ra  = RA_IDX;
				state_d = S_MIN_CMP;
			end
			S_MIN_CMP: begin
				cmd.ra      = RA_IDX_P1;
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_MIN;
				cmd.idx_inc = 1'b1;
				if (sts.idx_last) begin
					state_d = S_MIN_WR;
				end
			end
			S_MIN_WR: begin
				cmd.we      = 1'b1;
				cmd.wa      = WA_CNT;
				cmd.top_ld  = 1'b1;
				cmd.top_sel = TOP_RES;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/rpn_stack_calculator_top.sv -----
// divide runs on the iterative divider, one quotient bit per cycle; min reads every entry in turn
// one item in flight; the next input transfer is taken in the cycle after the result is loaded
// reset (arst_n low, asynchronous) empties the stack; ram contents are not cleared
module rpn_stack_calculator_top import rsc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] operand,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       stack_depth
);

	cmd_t cmd;
	sts_t sts;

	rsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rsc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.operand     (operand),
		.status      (status),
		.top_value   (top_value),
		.stack_depth (stack_depth)
	);

endmodule

// ----- hdl/rsc_checker.sv -----
// port-level checker for the rpn stack calculator and its bind
module rsc_checker import rsc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [ACT_W-1:0]         action,
	input logic signed [DATA_W-1:0] operand,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [ST_W-1:0]          status,
	input logic signed [DATA_W-1:0] top_value,
	input logic [DEPTH_W-1:0]       stack_depth
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(top_value)
			&& $stable(stack_depth)))
		else $error("stalled result changed");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (stack_depth == DEPTH_W'(STACK_DEPTH)))
		else $error("stack full flagged below capacity");

	a_empty_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (stack_depth == '0 && top_value == '0))
		else $error("drop on empty reported with entries");

	a_few_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FEW) |-> (stack_depth < DEPTH_W'(2)))
		else $error("too few operands flagged with two or more entries");

endmodule

bind rpn_stack_calculator_top rsc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rsc_checker (.*);
